FILE: sv/adam_weight_update_defines.svh
// Assertion macros shared by the adam_weight_update RTL.
// No dependencies; included by files that carry assertions.
`ifndef ADAM_WEIGHT_UPDATE_DEFINES_SVH
`define ADAM_WEIGHT_UPDATE_DEFINES_SVH

// clocked check, masked while in reset
`define AWU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, live during reset as well
`define AWU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/awu_pkg.sv
// Types, constants and helpers for the Adam weight update block.
// No dependencies.
package awu_pkg;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW = $clog2(MID_DEPTH);
  localparam int SQRT_STEPS = 28;
  localparam int DIV_BITS = 35;
  localparam int BK_STAGES = 1 + SQRT_STEPS + 1 + DIV_BITS;
  localparam int DIV_FIRST = SQRT_STEPS + 2;

  localparam logic [23:0] RST_BETA_FIRST = 24'd15099494;
  localparam logic [23:0] RST_BETA_SECOND = 24'd16760439;
  localparam logic [23:0] RST_EPSILON = 24'd1;
  localparam logic [31:0] RST_GRAD_SCALE = 32'd16777216;
  localparam logic [31:0] RST_CORR_RATE = 32'd16777;
  localparam logic [24:0] ONE_Q24 = 25'h100_0000;
  localparam logic [34:0] STEP_CAP = 35'h4_0000_0000;

  typedef enum logic [2:0] {
    REG_BETA_FIRST  = 3'd0,
    REG_BETA_SECOND = 3'd1,
    REG_EPSILON     = 3'd2,
    REG_GRAD_SCALE  = 3'd3,
    REG_CORR_RATE   = 3'd4
  } awu_reg_t;

  typedef struct packed {
    logic signed [31:0] old_weight;
    logic signed [31:0] gradient;
    logic signed [31:0] first_moment;
    logic [31:0]        second_moment;
  } awu_in_t;

  typedef struct packed {
    logic signed [31:0] new_weight;
    logic signed [31:0] new_first_moment;
    logic [31:0]        new_second_moment;
    logic               saturated;
  } awu_out_t;

  typedef struct packed {
    logic [23:0] beta_first;
    logic [23:0] beta_second;
    logic [23:0] epsilon;
    logic [31:0] grad_scale;
    logic [31:0] corrected_rate;
  } awu_cfg_t;

  typedef struct packed {
    logic signed [31:0] old_weight;
    logic signed [31:0] mn;
    logic [31:0]        vn;
    logic               flag;
  } awu_mid_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } awu_sat_t;

  function automatic awu_sat_t sat_s32(input logic signed [63:0] v);
    awu_sat_t r;
    if (v > 64'sd2147483647) begin
      r.val = 32'sh7fff_ffff;
      r.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'sh8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: sv/awu_front.sv
// Front end: gradient scaling and both moment updates, five stages.
// Depends on awu_pkg.
module awu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  awu_pkg::awu_cfg_t  cfg,
  input  logic               in_push,
  output logic               in_full,
  input  awu_pkg::awu_in_t   in_data,
  output logic               mid_push,
  input  logic               mid_full,
  output awu_pkg::awu_mid_t  mid_data
);
  import awu_pkg::*;

  logic [4:0] vld_r;
  logic adv;

  logic signed [31:0] s1_old_r, s1_m_r;
  logic [31:0]        s1_v_r;
  logic signed [63:0] s1_p_r;

  logic signed [31:0] s2_old_r, s2_m_r, s2_g_r;
  logic [31:0]        s2_v_r;
  logic               s2_flag_r;

  logic signed [31:0] s3_old_r;
  logic [31:0]        s3_v_r;
  logic signed [63:0] s3_pm1_r, s3_pm2_r;
  logic [63:0]        s3_sq_r;
  logic               s3_flag_r;

  logic signed [31:0] s4_old_r, s4_mn_r;
  logic [55:0]        s4_pv1_r;
  logic [64:0]        s4_pv2_r;
  logic               s4_flag_r;

  logic signed [31:0] s5_old_r, s5_mn_r;
  logic [31:0]        s5_vn_r;
  logic               s5_flag_r;

  awu_sat_t    g_sat, mn_sat;
  logic [31:0] gmag;
  logic [39:0] gsq;
  logic [64:0] vsum;
  logic [40:0] vsh;

  assign adv = !vld_r[4] || !mid_full;
  assign in_full = !adv;
  assign mid_push = vld_r[4] && !mid_full;
  assign mid_data = '{old_weight: s5_old_r, mn: s5_mn_r, vn: s5_vn_r, flag: s5_flag_r};

  always_comb begin
    g_sat = sat_s32(s1_p_r >>> 24);
    gmag = s2_g_r[31] ? 32'(-s2_g_r) : 32'(s2_g_r);
    mn_sat = sat_s32((s3_pm1_r + s3_pm2_r) >>> 24);
    gsq = s3_sq_r[63:24];
    vsum = 65'(s4_pv1_r) + s4_pv2_r;
    vsh = vsum[64:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_old_r <= in_data.old_weight;
      s1_m_r   <= in_data.first_moment;
      s1_v_r   <= in_data.second_moment;
      s1_p_r   <= 64'(in_data.gradient * $signed({1'b0, cfg.grad_scale}));

      s2_old_r  <= s1_old_r;
      s2_m_r    <= s1_m_r;
      s2_v_r    <= s1_v_r;
      s2_g_r    <= g_sat.val;
      s2_flag_r <= g_sat.sat;

      s3_old_r  <= s2_old_r;
      s3_v_r    <= s2_v_r;
      s3_pm1_r  <= 64'($signed({1'b0, cfg.beta_first}) * s2_m_r);
      s3_pm2_r  <= 64'($signed({1'b0, ONE_Q24 - 25'(cfg.beta_first)}) * s2_g_r);
      s3_sq_r   <= 64'(gmag) * 64'(gmag);
      s3_flag_r <= s2_flag_r;

      s4_old_r  <= s3_old_r;
      s4_mn_r   <= mn_sat.val;
      s4_pv1_r  <= 56'(cfg.beta_second) * 56'(s3_v_r);
      s4_pv2_r  <= 65'(ONE_Q24 - 25'(cfg.beta_second)) * 65'(gsq);
      s4_flag_r <= s3_flag_r || mn_sat.sat;

      s5_old_r  <= s4_old_r;
      s5_mn_r   <= s4_mn_r;
      s5_vn_r   <= (|vsh[40:32]) ? 32'hffff_ffff : vsh[31:0];
      s5_flag_r <= s4_flag_r || (|vsh[40:32]);
    end
  end

endmodule

FILE: sv/awu_fifo.sv
// Short queue that decouples the front end from the back end.
// Depends on awu_pkg and adam_weight_update_defines.svh.
`include "adam_weight_update_defines.svh"
module awu_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  awu_pkg::awu_mid_t  wdata,
  output logic               full,
  input  logic               pop,
  output awu_pkg::awu_mid_t  rdata,
  output logic               empty
);
  import awu_pkg::*;

  awu_mid_t          mem_r [MID_DEPTH];
  logic [MID_AW-1:0] wp_r, rp_r;
  logic [MID_AW:0]   cnt_r;

  assign full  = cnt_r == (MID_AW+1)'(MID_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  `AWU_ASSERT(a_no_overflow, push |-> !full || pop, "request pushed into full queue")
  `AWU_ASSERT(a_no_underflow, pop |-> !empty, "request popped from empty queue")
  `AWU_ASSERT(a_cnt_grow, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "queue count slip")
  `AWU_ASSERT(a_cnt_range, cnt_r <= (MID_AW+1)'(MID_DEPTH), "queue count out of range")

endmodule

FILE: sv/awu_back.sv
// Back end: square root, long division and weight update, pipelined.
// Depends on awu_pkg.
module awu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  awu_pkg::awu_cfg_t  cfg,
  input  logic               mid_empty,
  output logic               mid_pop,
  input  awu_pkg::awu_mid_t  mid_data,
  output logic               out_empty,
  input  logic               out_pop,
  output awu_pkg::awu_out_t  out_data
);
  import awu_pkg::*;

  typedef struct packed {
    logic signed [31:0] old_weight;
    logic signed [31:0] mn;
    logic [31:0]        vn;
    logic               flag;
    logic [63:0]        num;
    logic [55:0]        rad;
    logic [27:0]        root;
    logic [28:0]        rem;
    logic [28:0]        d;
    logic [34:0]        quo;
    logic               ovf;
  } bk_t;

  bk_t            st_r [BK_STAGES];
  bk_t            st_nxt [BK_STAGES];
  logic [BK_STAGES:0] vld_r;
  logic           adv;
  awu_out_t       out_r;
  logic [31:0]    mmag;
  logic [34:0]    qc;
  logic signed [63:0] step;
  awu_sat_t       w_sat;

  assign adv = !vld_r[BK_STAGES] || out_pop;
  assign mid_pop = adv && !mid_empty;
  assign out_empty = !vld_r[BK_STAGES];
  assign out_data = out_r;

  always_comb begin
    mmag = mid_data.mn[31] ? 32'(-mid_data.mn) : 32'(mid_data.mn);
    st_nxt[0] = '0;
    st_nxt[0].old_weight = mid_data.old_weight;
    st_nxt[0].mn = mid_data.mn;
    st_nxt[0].vn = mid_data.vn;
    st_nxt[0].flag = mid_data.flag;
    st_nxt[0].num = 64'(cfg.corrected_rate) * 64'(mmag);
    st_nxt[0].rad = {mid_data.vn, 24'd0};
  end

  for (genvar s = 1; s < BK_STAGES; s++) begin : g_stage
    if (s <= SQRT_STEPS) begin : g_sqrt
      logic [31:0] cur, trial;
      always_comb begin
        st_nxt[s] = st_r[s-1];
        cur = {st_r[s-1].rem[29-1:0], st_r[s-1].rad[55:54]} & 32'h3fff_ffff;
        trial = {2'b00, st_r[s-1].root, 2'b01};
        st_nxt[s].rad = {st_r[s-1].rad[53:0], 2'b00};
        if (cur >= trial) begin
          st_nxt[s].rem = 29'(cur - trial);
          st_nxt[s].root = {st_r[s-1].root[26:0], 1'b1};
        end else begin
          st_nxt[s].rem = 29'(cur);
          st_nxt[s].root = {st_r[s-1].root[26:0], 1'b0};
        end
      end
    end else if (s == SQRT_STEPS + 1) begin : g_prep
      logic [28:0] dsum;
      always_comb begin
        st_nxt[s] = st_r[s-1];
        dsum = 29'(st_r[s-1].root) + 29'(cfg.epsilon);
        st_nxt[s].d = (dsum == '0) ? 29'd1 : dsum;
        st_nxt[s].ovf = 29'(st_r[s-1].num[62:35]) >= st_nxt[s].d;
        st_nxt[s].rem = 29'(st_r[s-1].num[62:35]);
        st_nxt[s].quo = '0;
      end
    end else begin : g_div
      localparam int K = DIV_BITS - 1 - (s - DIV_FIRST);
      logic [29:0] cur;
      always_comb begin
        st_nxt[s] = st_r[s-1];
        cur = {st_r[s-1].rem, st_r[s-1].num[K]};
        if (cur >= 30'(st_r[s-1].d)) begin
          st_nxt[s].rem = 29'(cur - 30'(st_r[s-1].d));
          st_nxt[s].quo = {st_r[s-1].quo[33:0], 1'b1};
        end else begin
          st_nxt[s].rem = 29'(cur);
          st_nxt[s].quo = {st_r[s-1].quo[33:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qc = (st_r[BK_STAGES-1].ovf || st_r[BK_STAGES-1].quo > STEP_CAP)
         ? STEP_CAP : st_r[BK_STAGES-1].quo;
    step = st_r[BK_STAGES-1].mn[31] ? -$signed(64'(qc)) : $signed(64'(qc));
    w_sat = sat_s32(64'(st_r[BK_STAGES-1].old_weight) - step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BK_STAGES-1:0], mid_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < BK_STAGES; i++) st_r[i] <= st_nxt[i];
      out_r.new_weight <= w_sat.val;
      out_r.new_first_moment <= st_r[BK_STAGES-1].mn;
      out_r.new_second_moment <= st_r[BK_STAGES-1].vn;
      out_r.saturated <= st_r[BK_STAGES-1].flag || w_sat.sat;
    end
  end

endmodule

FILE: sv/adam_weight_update.sv
// Top level of the Adam weight update block: registers, front, queue, back.
// Depends on awu_pkg, awu_front, awu_fifo and awu_back.
//
//   channel  ports                          moves
//   in       in_push, in_full, in_data      one weight request
//   out      out_empty, out_pop, out_data   one updated weight
//   cfg      cfg_we, cfg_index, cfg_wdata   one register write
//
// One request per cycle sustained while results are popped; a request passes, in order,
// five front stages, queue write, multiply stage, 28 root steps, divisor set-up,
// 35 divide steps and the output register.
// Synchronous active-low reset empties all stages and loads register defaults.
// A held result stalls the back end; the queue then fills and stalls the front.
module adam_weight_update (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  awu_pkg::awu_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output awu_pkg::awu_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import awu_pkg::*;

  awu_cfg_t cfg_r;
  awu_mid_t mid_wdata, mid_rdata;
  logic     mid_push, mid_full, mid_pop, mid_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta_first     <= RST_BETA_FIRST;
      cfg_r.beta_second    <= RST_BETA_SECOND;
      cfg_r.epsilon        <= RST_EPSILON;
      cfg_r.grad_scale     <= RST_GRAD_SCALE;
      cfg_r.corrected_rate <= RST_CORR_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BETA_FIRST:  cfg_r.beta_first <= cfg_wdata[23:0];
        REG_BETA_SECOND: cfg_r.beta_second <= cfg_wdata[23:0];
        REG_EPSILON:     cfg_r.epsilon <= cfg_wdata[23:0];
        REG_GRAD_SCALE:  cfg_r.grad_scale <= cfg_wdata;
        REG_CORR_RATE:   cfg_r.corrected_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  awu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push && !in_full),
    .in_full  (in_full),
    .in_data  (in_data),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_data (mid_wdata)
  );

  awu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  awu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_data  (mid_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
